// File: rtl/core/hsk_pkg.sv
// Shared types, codes and helpers for the node registration handshake core.
package hsk_pkg;

   localparam logic [1:0] ACT_SEND = 2'd0;
   localparam logic [1:0] ACT_RECV = 2'd1;
   localparam logic [1:0] ACT_POLL = 2'd2;

   localparam logic [1:0] ST_REG   = 2'd0;
   localparam logic [1:0] ST_ACK   = 2'd1;
   localparam logic [1:0] ST_READY = 2'd2;

   localparam logic [3:0] TYPE_REG = 4'd0;
   localparam logic [3:0] TYPE_ACK = 4'd1;

   localparam logic [1:0] CSR_NODE_MODE     = 2'd0;
   localparam logic [1:0] CSR_OWN_ID        = 2'd1;
   localparam logic [1:0] CSR_CONTROLLER_ID = 2'd2;
   localparam logic [1:0] CSR_MAGIC_WORD    = 2'd3;

   localparam logic [15:0] MAGIC_RESET = 16'd132;
   localparam logic [7:0]  HDR_BYTES   = 8'd8;
   localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
   localparam int          TYPE_SHIFT  = 27;
   localparam int          ID_SHIFT    = 23;
   localparam int          MASK_BITS   = 4;

   typedef struct packed {
      logic        node_mode;
      logic [3:0]  own_id;
      logic [3:0]  controller_id;
      logic [15:0] magic_word;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [47:0] peer_mac;
      logic        send_ok;
      logic [7:0]  msg_len;
      logic [31:0] msg_flags;
      logic [15:0] msg_magic;
      logic        crc_ok;
      logic        tx_ready;
   } req_type;

   typedef struct packed {
      logic        send_request;
      logic        send_broadcast;
      logic [47:0] dest_mac;
      logic [31:0] send_flags;
      logic        add_peer;
      logic        msg_dropped;
   } rsp_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  slot;
      logic [1:0]  slot_state;
   } tbl_look_type;

   typedef struct packed {
      logic        state_we;
      logic [3:0]  state_idx;
      logic [1:0]  state_val;
      logic        mac_we;
      logic [3:0]  mac_idx;
      logic [47:0] mac_val;
   } tbl_wr_type;

   function automatic logic [31:0] make_flags(logic unicast, logic [3:0] kind, logic [3:0] id);
      logic [31:0] f;
      f = '0;
      f[31] = unicast;
      f[TYPE_SHIFT +: 4] = kind;
      f[ID_SHIFT +: 4] = id;
      return f;
   endfunction

endpackage

// File: rtl/core/hsk_table.sv
// Per-client state and station address table with parallel address lookup.
module hsk_table #(
   parameter int CLIENT_SLOTS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hsk_pkg::tbl_wr_type   wr,
   input  logic [47:0]           lk_mac,
   output hsk_pkg::tbl_look_type look,
   output logic                  all_ready,
   output logic [3:0]            ready_mask
);
   import hsk_pkg::*;

   localparam int SLOT_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
   localparam int MASK_W = (CLIENT_SLOTS < MASK_BITS) ? CLIENT_SLOTS : MASK_BITS;

   logic [1:0]  state_ff [CLIENT_SLOTS];
   logic [47:0] mac_ff   [CLIENT_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CLIENT_SLOTS; i++) begin
            state_ff[i] <= ST_REG;
            mac_ff[i]   <= '0;
         end
      end else begin
         if (wr.state_we) begin
            state_ff[wr.state_idx[SLOT_W-1:0]] <= wr.state_val;
         end
         if (wr.mac_we) begin
            mac_ff[wr.mac_idx[SLOT_W-1:0]] <= wr.mac_val;
         end
      end
   end

   // first matching entry wins, so scan from the top down
   always_comb begin
      look = '0;
      for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
         if (mac_ff[i] == lk_mac) begin
            look.hit        = 1'b1;
            look.slot       = 4'(i);
            look.slot_state = state_ff[i];
         end
      end
   end

   always_comb begin
      all_ready = 1'b1;
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
         if (state_ff[i] != ST_READY) begin
            all_ready = 1'b0;
         end
      end
   end

   // mask reflects the table after this request's write
   always_comb begin
      ready_mask = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (wr.state_we && wr.state_idx == 4'(i)) begin
            ready_mask[i] = (wr.state_val == ST_READY);
         end else begin
            ready_mask[i] = (state_ff[i] == ST_READY);
         end
      end
   end

endmodule

// File: rtl/core/hsk_logic.sv
// Decision logic for one request: validation, controller and client behaviour.
module hsk_logic #(
   parameter int CLIENT_SLOTS = 4
) (
   input  hsk_pkg::req_type      req,
   input  hsk_pkg::cfg_type      cfg,
   input  logic [1:0]            conn_state,
   input  hsk_pkg::tbl_look_type look,
   input  logic                  all_ready,
   output hsk_pkg::rsp_type      rsp,
   output logic [1:0]            conn_next,
   output hsk_pkg::tbl_wr_type   wr
);
   import hsk_pkg::*;

   logic [3:0] msg_kind;
   logic [3:0] msg_id;
   logic [3:0] my_id;
   logic       msg_ok;
   logic       id_in_range;

   assign msg_kind    = req.msg_flags[TYPE_SHIFT +: 4];
   assign msg_id      = req.msg_flags[ID_SHIFT +: 4];
   assign my_id       = cfg.node_mode ? cfg.controller_id : cfg.own_id;
   assign msg_ok      = (req.msg_len >= HDR_BYTES) && (req.msg_magic == cfg.magic_word) &&
                        req.crc_ok;
   assign id_in_range = ({1'b0, msg_id} < 5'(CLIENT_SLOTS));

   always_comb begin
      rsp       = '0;
      conn_next = conn_state;
      wr        = '0;
      if (req.action == ACT_RECV && !msg_ok) begin
         rsp.msg_dropped = 1'b1;
      end else if (cfg.node_mode) begin
         case (req.action)
            ACT_SEND: begin
               if (req.peer_mac != MAC_BCAST && look.hit && look.slot_state == ST_ACK) begin
                  if (req.send_ok) begin
                     wr.state_we  = 1'b1;
                     wr.state_idx = look.slot;
                     wr.state_val = ST_READY;
                  end else if (req.tx_ready) begin
                     rsp.send_request = 1'b1;
                     rsp.dest_mac     = req.peer_mac;
                     rsp.send_flags   = make_flags(1'b1, TYPE_ACK, my_id);
                  end
               end
            end
            ACT_RECV: begin
               if (msg_kind == TYPE_ACK && id_in_range) begin
                  wr.mac_we    = 1'b1;
                  wr.mac_idx   = msg_id;
                  wr.mac_val   = req.peer_mac;
                  rsp.add_peer = 1'b1;
                  if (req.tx_ready) begin
                     rsp.send_request = 1'b1;
                     rsp.dest_mac     = req.peer_mac;
                     rsp.send_flags   = make_flags(1'b1, TYPE_ACK, my_id);
                     wr.state_we      = 1'b1;
                     wr.state_idx     = msg_id;
                     wr.state_val     = ST_ACK;
                  end
               end
            end
            ACT_POLL: begin
               if (conn_state == ST_REG) begin
                  if (all_ready) begin
                     conn_next = ST_READY;
                  end else if (req.tx_ready) begin
                     rsp.send_request   = 1'b1;
                     rsp.send_broadcast = 1'b1;
                     rsp.dest_mac       = MAC_BCAST;
                     rsp.send_flags     = make_flags(1'b0, TYPE_REG, my_id);
                  end
               end
            end
            default: ;
         endcase
      end else begin
         case (req.action)
            ACT_SEND: begin
               if (!req.send_ok && conn_state == ST_ACK) begin
                  conn_next = ST_REG;
               end
            end
            ACT_RECV: begin
               if (conn_state == ST_REG) begin
                  if (msg_kind == TYPE_REG) begin
                     rsp.add_peer = 1'b1;
                     if (req.tx_ready) begin
                        rsp.send_request = 1'b1;
                        rsp.dest_mac     = req.peer_mac;
                        rsp.send_flags   = make_flags(1'b1, TYPE_ACK, my_id);
                        conn_next        = ST_ACK;
                     end
                  end
               end else if (conn_state == ST_ACK) begin
                  if (msg_kind == TYPE_ACK && msg_id == cfg.controller_id) begin
                     conn_next = ST_READY;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/core/node_registration_handshake_core.sv
// Top level of the node registration handshake core.
//
// Usage: events (send completion, received message, poll tick) arrive on the
// req_ channel, one request per valid/stall handshake. Each request yields
// exactly one response on the rsp_ channel: the message to transmit if any,
// add-peer and drop indications, the own link state and the client ready mask.
// rsp_valid rises once the request has moved from the input register through the
// decision logic and table update, whose outcome lands in the response register.
// Throughput is one request per cycle unless the response is stalled; the table
// lookup and all state updates are applied as the request advances out of the
// input register, so back-to-back requests see each other's effects in order.
// When the receiver holds rsp_stall, the response register holds its contents;
// one further request may sit in the input register, after which req_stall is
// raised until the response is taken.
// Synchronous reset clears the link state, the client state and address tables
// and restores the configuration to its defaults (magic 132, client mode).
// Write configuration via csr_wr_en/csr_index/csr_wdata only when idle; unenforced.
module node_registration_handshake_core #(
   parameter int CLIENT_SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [47:0] req_peer_mac,
   input  logic        req_send_ok,
   input  logic [7:0]  req_msg_len,
   input  logic [31:0] req_msg_flags,
   input  logic [15:0] req_msg_magic,
   input  logic        req_crc_ok,
   input  logic        req_tx_ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_send_request,
   output logic        rsp_send_broadcast,
   output logic [47:0] rsp_dest_mac,
   output logic [31:0] rsp_send_flags,
   output logic        rsp_add_peer,
   output logic        rsp_msg_dropped,
   output logic [1:0]  rsp_link_state,
   output logic [3:0]  rsp_ready_mask
);
   import hsk_pkg::*;

   cfg_type      cfg_ff;
   logic         in_valid_ff;
   req_type      in_ff;
   logic         out_valid_ff;
   rsp_type      out_ff;
   logic [1:0]   link_ff;
   logic [3:0]   mask_ff;
   logic [1:0]   conn_state_ff;
   logic [1:0]   conn_state_in;
   logic         advance;
   rsp_type      rsp_in;
   tbl_wr_type   wr_raw;
   tbl_wr_type   wr_gated;
   tbl_look_type look;
   logic         all_ready;
   logic [3:0]   mask_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_mode     <= 1'b0;
         cfg_ff.own_id        <= '0;
         cfg_ff.controller_id <= '0;
         cfg_ff.magic_word    <= MAGIC_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NODE_MODE:     cfg_ff.node_mode     <= csr_wdata[0];
            CSR_OWN_ID:        cfg_ff.own_id        <= csr_wdata[3:0];
            CSR_CONTROLLER_ID: cfg_ff.controller_id <= csr_wdata[3:0];
            CSR_MAGIC_WORD:    cfg_ff.magic_word    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance   = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff.action    <= req_action;
         in_ff.peer_mac  <= req_peer_mac;
         in_ff.send_ok   <= req_send_ok;
         in_ff.msg_len   <= req_msg_len;
         in_ff.msg_flags <= req_msg_flags;
         in_ff.msg_magic <= req_msg_magic;
         in_ff.crc_ok    <= req_crc_ok;
         in_ff.tx_ready  <= req_tx_ready;
      end
   end

   hsk_logic #(
      .CLIENT_SLOTS(CLIENT_SLOTS)
   ) u_logic (
      .req        (in_ff),
      .cfg        (cfg_ff),
      .conn_state (conn_state_ff),
      .look       (look),
      .all_ready  (all_ready),
      .rsp        (rsp_in),
      .conn_next  (conn_state_in),
      .wr         (wr_raw)
   );

   assign wr_gated = advance ? wr_raw : '0;

   hsk_table #(
      .CLIENT_SLOTS(CLIENT_SLOTS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr_gated),
      .lk_mac     (in_ff.peer_mac),
      .look       (look),
      .all_ready  (all_ready),
      .ready_mask (mask_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         conn_state_ff <= ST_REG;
      end else if (advance) begin
         conn_state_ff <= conn_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff  <= rsp_in;
         link_ff <= conn_state_in;
         mask_ff <= mask_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_send_request   = out_ff.send_request;
   assign rsp_send_broadcast = out_ff.send_broadcast;
   assign rsp_dest_mac       = out_ff.dest_mac;
   assign rsp_send_flags     = out_ff.send_flags;
   assign rsp_add_peer       = out_ff.add_peer;
   assign rsp_msg_dropped    = out_ff.msg_dropped;
   assign rsp_link_state     = link_ff;
   assign rsp_ready_mask     = mask_ff;

   a_drop_is_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_msg_dropped |-> !rsp_send_request && !rsp_add_peer)
      else $error("dropped request produced a send or peer add");

   a_idle_send_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_request |->
         !rsp_send_broadcast && rsp_dest_mac == '0 && rsp_send_flags == '0)
      else $error("send fields not cleared without a send");

   a_bcast_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_broadcast |-> rsp_send_request && rsp_dest_mac == MAC_BCAST)
      else $error("broadcast response with wrong destination");

   a_advance_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid && rsp_link_state == $past(conn_state_in))
      else $error("advanced request did not reach the response register");

   a_no_table_write_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |-> !wr_gated.state_we && !wr_gated.mac_we)
      else $error("table written without an advancing request");

endmodule
